// File: rtl/crq_pkg.sv
`default_nettype none

package crq_pkg;

    localparam int ID_W     = 16;
    localparam int VOL_W    = 8;
    localparam int STATUS_W = 3;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [STATUS_W-1:0] ST_MERGED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_STARTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [VOL_W-1:0] vol;
    } entry_t;

endpackage

`default_nettype wire

// File: rtl/coalescing_request_queue.sv
// Coalescing request queue: a ring of DEPTH slots of pending play requests.
// Input channel (in_valid / in_stall): one beat is a push (opcode 0) carrying
// sound_id and volume, or a tick (opcode 1) that pops the oldest request.
// Output channel (out_valid / out_stall): exactly one beat per input beat,
// carrying status, out_sound_id and out_volume, in input order.
// A push compares the pending entries one per cycle, oldest first, out of
// the slot memory; a match keeps the larger volume in place, otherwise the
// request is written at the tail, or dropped when DEPTH-1 entries are pending.
// A push holds the input while it compares the pending entries, a tick while
// it reads the head, if any. The result is loaded into the result register and
// then, in S_OUT, into the output register once that register is free.
// One item is worked at a time; the result register lets the next beat be
// accepted while an earlier result is still held by out_stall. A finished
// result waits in the block until the output register frees up, and no input
// is accepted meanwhile.
// Reset (rst_n low) empties the ring and clears out_valid; no clearing pass.
`default_nettype none

module coalescing_request_queue
    import crq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire                  opcode,
    input  wire  [ID_W-1:0]      sound_id,
    input  wire  [VOL_W-1:0]     volume,
    output logic                 out_valid,
    input  wire                  out_stall,
    output logic [STATUS_W-1:0]  status,
    output logic [ID_W-1:0]      out_sound_id,
    output logic [VOL_W-1:0]     out_volume
);

    localparam int PTR_W = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POP,
        S_OUT
    } state_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    state_t               state_reg, state_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     scan_ptr_reg, scan_ptr_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [PTR_W-1:0]     cmp_addr_reg, cmp_addr_next;
    logic [ID_W-1:0]      req_id_reg, req_id_next;
    logic [VOL_W-1:0]     req_vol_reg, req_vol_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [ID_W-1:0]      res_id_reg, res_id_next;
    logic [VOL_W-1:0]     res_vol_reg, res_vol_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [ID_W-1:0]      out_id_reg, out_id_next;
    logic [VOL_W-1:0]     out_vol_reg, out_vol_next;

    logic                 mem_we;
    logic [PTR_W-1:0]     mem_waddr;
    entry_t               mem_wdata;
    logic [PTR_W-1:0]     mem_raddr;

    logic                 empty;
    logic                 full;
    logic                 hit;
    logic [VOL_W-1:0]     max_vol;

    assign empty   = (rd_ptr_reg == wr_ptr_reg);
    assign full    = (ring_next(wr_ptr_reg) == rd_ptr_reg);
    assign hit     = cmp_vld_reg && (rdata_reg.id == req_id_reg);
    assign max_vol = (req_vol_reg > rdata_reg.vol) ? req_vol_reg : rdata_reg.vol;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        scan_ptr_next   = scan_ptr_reg;
        cmp_vld_next    = 1'b0;
        cmp_addr_next   = cmp_addr_reg;
        req_id_next     = req_id_reg;
        req_vol_next    = req_vol_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_vol_next    = res_vol_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        out_id_next     = out_id_reg;
        out_vol_next    = out_vol_reg;
        mem_we          = 1'b0;
        mem_waddr       = wr_ptr_reg;
        mem_wdata       = '{id: req_id_reg, vol: req_vol_reg};
        mem_raddr       = rd_ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_id_next  = sound_id;
                    req_vol_next = volume;
                    if (opcode == OP_PUSH)
                    begin
                        // head read issued now, compared next cycle
                        cmp_vld_next  = !empty;
                        cmp_addr_next = rd_ptr_reg;
                        scan_ptr_next = empty ? rd_ptr_reg : ring_next(rd_ptr_reg);
                        state_next    = S_SCAN;
                    end
                    else if (empty)
                    begin
                        res_status_next = ST_EMPTY;
                        res_id_next     = '0;
                        res_vol_next    = '0;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        state_next = S_POP;
                    end
                end
            end

            S_SCAN:
            begin
                mem_raddr = scan_ptr_reg;
                if (hit)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = cmp_addr_reg;
                    mem_wdata       = '{id: req_id_reg, vol: max_vol};
                    res_status_next = ST_MERGED;
                    res_id_next     = req_id_reg;
                    res_vol_next    = max_vol;
                    state_next      = S_OUT;
                end
                else if (scan_ptr_reg != wr_ptr_reg)
                begin
                    cmp_vld_next  = 1'b1;
                    cmp_addr_next = scan_ptr_reg;
                    scan_ptr_next = ring_next(scan_ptr_reg);
                end
                else
                begin
                    res_id_next  = req_id_reg;
                    res_vol_next = req_vol_reg;
                    if (full)
                    begin
                        res_status_next = ST_DROPPED;
                    end
                    else
                    begin
                        mem_we          = 1'b1;
                        wr_ptr_next     = ring_next(wr_ptr_reg);
                        res_status_next = ST_QUEUED;
                    end
                    state_next = S_OUT;
                end
            end

            S_POP:
            begin
                res_status_next = ST_STARTED;
                res_id_next     = rdata_reg.id;
                res_vol_next    = rdata_reg.vol;
                rd_ptr_next     = ring_next(rd_ptr_reg);
                state_next      = S_OUT;
            end

            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    out_id_next    = res_id_reg;
                    out_vol_next   = res_vol_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            scan_ptr_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_addr_reg   <= '0;
            req_id_reg     <= '0;
            req_vol_reg    <= '0;
            res_status_reg <= ST_EMPTY;
            res_id_reg     <= '0;
            res_vol_reg    <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_EMPTY;
            out_id_reg     <= '0;
            out_vol_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            scan_ptr_reg   <= scan_ptr_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_addr_reg   <= cmp_addr_next;
            req_id_reg     <= req_id_next;
            req_vol_reg    <= req_vol_next;
            res_status_reg <= res_status_next;
            res_id_reg     <= res_id_next;
            res_vol_reg    <= res_vol_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            out_id_reg     <= out_id_next;
            out_vol_reg    <= out_vol_next;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_sound_id = out_id_reg;
    assign out_volume   = out_vol_reg;

endmodule

`default_nettype wire

// File: rtl/crq_checker.sv
`default_nettype none

module crq_checker
    import crq_pkg::*;
(
    input wire                 clk,
    input wire                 rst_n,
    input wire                 in_valid,
    input wire                 in_stall,
    input wire                 out_valid,
    input wire                 out_stall,
    input wire [STATUS_W-1:0]  status,
    input wire [ID_W-1:0]      out_sound_id,
    input wire [VOL_W-1:0]     out_volume
);

    // one item in flight: busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted on back-to-back cycles");

    // a result never shows up the cycle right after its beat
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared one cycle after accept");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> out_sound_id == '0 && out_volume == '0)
        else $error("nothing-pending result carries nonzero payload");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(out_sound_id) && $stable(out_volume))
        else $error("stalled output beat changed");

endmodule

bind coalescing_request_queue crq_checker u_crq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_sound_id (out_sound_id),
    .out_volume   (out_volume)
);

`default_nettype wire
